// File: src/lshd_pkg.sv
// ----------------------------------------------------------------------------
// lshd_pkg
// Shared widths and types of the signature hint-section decoder.
// ----------------------------------------------------------------------------
package lshd_pkg;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 64;
  localparam int WIDX_W    = 5;
  localparam int MAX_POLYS = 8;
  localparam int POLY_W    = 3;

  typedef logic [MAX_POLYS-1:0][BYTE_W-1:0] lshd_cnt_arr_t;

  // one finished section, handed from the loader to the decoder
  typedef struct packed {
    logic          bank;
    logic          count_err;
    lshd_cnt_arr_t counts;
  } lshd_tok_t;

  // decoder gives a section bank back to the loader
  typedef struct packed {
    logic valid;
    logic bank;
  } lshd_rel_t;

endpackage

// File: src/lshd_ifs.sv
// ----------------------------------------------------------------------------
// lshd channel interfaces
// Valid/ready channels for section bytes in and hint words out.
// ----------------------------------------------------------------------------
interface lshd_in_if
  import lshd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] section_byte;

  modport source (output valid, output section_byte, input ready);
  modport sink   (input valid, input section_byte, output ready);
endinterface

interface lshd_out_if
  import lshd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] hint_word;
  logic [WIDX_W-1:0] word_index;
  logic              malformed;
  logic              last_word;

  modport source (output valid, output hint_word, output word_index, output malformed,
                  output last_word, input ready);
  modport sink   (input valid, input hint_word, input word_index, input malformed,
                  input last_word, output ready);
endinterface

// File: src/lattice_sig_hint_decoder.sv
// ----------------------------------------------------------------------------
// lattice_sig_hint_decoder
// Unpacks the hint section of a lattice signature into 64-bit hint words.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                            handshake
//  sec_i    in   section_byte[7:0]                                  valid/ready
//  hint_o   out  hint_word[63:0] word_index[4:0] malformed last_word valid/ready
//
// a byte is stored every cycle sec_i.ready is high, in one bank of a two-bank section RAM
// per polynomial the decoder takes a start step, visits each index slot with a RAM read
// and a check, and flushes the polynomial's words into the word RAM; it emits each word
// by a word RAM read and an output load, while the loader may fill the other bank
// reset clears control state and pbuf; no clearing pass, hint words rewritten per section
// sec_i.ready drops only while both banks wait for, or are in, decoding
module lattice_sig_hint_decoder
  import lshd_pkg::*;
#(
  parameter int MAX_HINTS = 55,
  parameter int POLYS     = 6,
  parameter int COEFFS    = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lshd_in_if.sink    sec_i,
  lshd_out_if.source hint_o
);

  localparam int SECTION_LEN = MAX_HINTS + POLYS;
  localparam int PW          = $clog2(SECTION_LEN);
  localparam int SDEPTH      = 2 * (2 ** PW);

  logic              s_we;
  logic [PW:0]       s_waddr;
  logic [BYTE_W-1:0] s_wdata;
  logic [PW:0]       s_raddr;
  logic [BYTE_W-1:0] s_rdata;

  logic              push;
  lshd_tok_t         push_tok;
  logic              q_full;
  logic              q_valid;
  lshd_tok_t         q_tok;
  logic              q_pop;
  lshd_rel_t         rel;

  lshd_front #(
    .MAX_HINTS (MAX_HINTS),
    .POLYS     (POLYS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sec_i    (sec_i),
    .we_o     (s_we),
    .waddr_o  (s_waddr),
    .wdata_o  (s_wdata),
    .push_o   (push),
    .tok_o    (push_tok),
    .q_full_i (q_full),
    .rel_i    (rel)
  );

  lshd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SDEPTH)
  ) u_section_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  lshd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (push_tok),
    .full_o  (q_full),
    .valid_o (q_valid),
    .tok_o   (q_tok),
    .pop_i   (q_pop)
  );

  lshd_back #(
    .MAX_HINTS (MAX_HINTS),
    .POLYS     (POLYS),
    .COEFFS    (COEFFS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_tok_i   (q_tok),
    .q_pop_o   (q_pop),
    .rel_o     (rel),
    .s_raddr_o (s_raddr),
    .s_rdata_i (s_rdata),
    .hint_o    (hint_o)
  );

endmodule

// File: src/lshd_ram.sv
// ----------------------------------------------------------------------------
// lshd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lshd_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/lshd_queue.sv
// ----------------------------------------------------------------------------
// lshd_queue
// Two-entry queue of finished sections between loader and decoder.
// ----------------------------------------------------------------------------
module lshd_queue
  import lshd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lshd_tok_t tok_i,
  output logic      full_o,
  output logic      valid_o,
  output lshd_tok_t tok_o,
  input  logic      pop_i
);

  lshd_tok_t  ent_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign tok_o   = ent_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = !wp_q;
    end
    if (pop_i) begin
      rp_d = !rp_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= tok_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("section queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("section queue popped while empty");

endmodule

// File: src/lshd_front.sv
// ----------------------------------------------------------------------------
// lshd_front
// Loads section bytes into a two-bank store and checks the counts on the fly.
// ----------------------------------------------------------------------------
module lshd_front
  import lshd_pkg::*;
#(
  parameter  int MAX_HINTS   = 55,
  parameter  int POLYS       = 6,
  localparam int SECTION_LEN = MAX_HINTS + POLYS,
  localparam int PW          = $clog2(SECTION_LEN)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lshd_in_if.sink           sec_i,
  output logic              we_o,
  output logic [PW:0]       waddr_o,
  output logic [BYTE_W-1:0] wdata_o,
  output logic              push_o,
  output lshd_tok_t         tok_o,
  input  logic              q_full_i,
  input  lshd_rel_t         rel_i
);

  logic [PW-1:0]     pos_q, pos_d;
  logic              wbank_q, wbank_d;
  logic [1:0]        busy_q, busy_d;
  logic [BYTE_W-1:0] prev_q, prev_d;
  logic              err_q, err_d;
  lshd_cnt_arr_t     counts_q, counts_d;

  logic              acc;
  logic              is_cnt;
  logic              is_last;
  logic [8:0]        pos_ext;
  logic [8:0]        off;
  logic [POLY_W-1:0] pidx;
  logic [BYTE_W-1:0] raw;
  logic [BYTE_W-1:0] cnt;
  logic              bad;

  assign sec_i.ready = !busy_q[wbank_q] && !q_full_i;
  assign acc         = sec_i.valid && sec_i.ready;
  assign raw         = sec_i.section_byte;

  assign pos_ext = 9'(pos_q);
  assign off     = pos_ext - 9'(MAX_HINTS);
  assign pidx    = off[POLY_W-1:0];
  assign is_cnt  = (pos_ext >= 9'(MAX_HINTS));
  assign is_last = (pos_ext == 9'(SECTION_LEN - 1));

  // counts are clamped to the slot count, backwards or oversized ones flag
  assign cnt = (raw > 8'(MAX_HINTS)) ? 8'(MAX_HINTS) : raw;
  assign bad = (raw < prev_q) || (raw > 8'(MAX_HINTS));

  always_comb begin
    pos_d    = pos_q;
    wbank_d  = wbank_q;
    busy_d   = busy_q;
    prev_d   = prev_q;
    err_d    = err_q;
    counts_d = counts_q;
    if (acc) begin
      if (is_cnt) begin
        counts_d[pidx] = cnt;
        prev_d         = cnt;
        err_d          = err_q | bad;
      end
      if (is_last) begin
        pos_d           = '0;
        wbank_d         = !wbank_q;
        prev_d          = '0;
        err_d           = 1'b0;
        busy_d[wbank_q] = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      wbank_q <= 1'b0;
      busy_q  <= 2'b00;
      prev_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      wbank_q <= wbank_d;
      busy_q  <= busy_d;
      prev_q  <= prev_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    counts_q <= counts_d;
  end

  assign we_o    = acc;
  assign waddr_o = {wbank_q, pos_q};
  assign wdata_o = raw;

  // the last byte of a section is always a count byte
  assign push_o = acc && is_last;
  always_comb begin
    tok_o.bank      = wbank_q;
    tok_o.count_err = err_q | bad;
    tok_o.counts    = counts_d;
  end

  a_bank_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> busy_q[$past(wbank_q)])
    else $error("filled bank not held for the decoder");

endmodule

// File: src/lshd_back.sv
// ----------------------------------------------------------------------------
// lshd_back
// Walks one stored section, rebuilds the hint vector and sends it out by word.
// ----------------------------------------------------------------------------
module lshd_back
  import lshd_pkg::*;
#(
  parameter  int MAX_HINTS   = 55,
  parameter  int POLYS       = 6,
  parameter  int COEFFS      = 256,
  localparam int SECTION_LEN = MAX_HINTS + POLYS,
  localparam int PW          = $clog2(SECTION_LEN),
  localparam int WPP         = (COEFFS + 63) / 64,
  localparam int PBW         = WPP * WORD_W,
  localparam int PBI         = $clog2(PBW),
  localparam int KW          = (WPP > 1) ? $clog2(WPP) : 1,
  localparam int TOTAL_WORDS = POLYS * WPP,
  localparam int WAW         = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  lshd_tok_t         q_tok_i,
  output logic              q_pop_o,
  output lshd_rel_t         rel_o,
  output logic [PW:0]       s_raddr_o,
  input  logic [BYTE_W-1:0] s_rdata_i,
  lshd_out_if.source        hint_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_PSTART = 10'b0000000010,
    S_RD     = 10'b0000000100,
    S_EX     = 10'b0000001000,
    S_FLUSH  = 10'b0000010000,
    S_TSTART = 10'b0000100000,
    S_TRD    = 10'b0001000000,
    S_TEX    = 10'b0010000000,
    S_ERD    = 10'b0100000000,
    S_ELD    = 10'b1000000000
  } lshd_bst_e;

  lshd_bst_e         st_q, st_d;
  lshd_tok_t         tok_q, tok_d;
  logic [POLY_W-1:0] p_q, p_d;
  logic [BYTE_W-1:0] j_q, j_d;
  logic [BYTE_W-1:0] prev_q, prev_d;
  logic [BYTE_W-1:0] last_q, last_d;
  logic              first_q, first_d;
  logic              err_q, err_d;
  logic [PBW-1:0]    pbuf_q, pbuf_d;
  logic [KW-1:0]     k_q, k_d;
  logic [WAW-1:0]    wa_q, wa_d;
  logic [WAW-1:0]    w_q, w_d;

  logic              ov_q, ov_d;
  logic [WORD_W-1:0] hw_q, hw_d;
  logic [WIDX_W-1:0] wi_q, wi_d;
  logic              mf_q, mf_d;
  logic              lw_q, lw_d;

  logic [BYTE_W-1:0] cnt_p;
  logic [BYTE_W-1:0] j_inc;
  logic              wwe;
  logic [WORD_W-1:0] wwdata;
  logic [WORD_W-1:0] wrdata;
  logic              w_last;

  assign cnt_p     = tok_q.counts[p_q];
  assign j_inc     = j_q + 8'd1;
  assign s_raddr_o = {tok_q.bank, PW'(j_q)};
  assign wwdata    = pbuf_q[{k_q, 6'd0} +: WORD_W];
  assign w_last    = (w_q == WAW'(TOTAL_WORDS - 1));

  lshd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TOTAL_WORDS)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (wwe),
    .waddr_i (wa_q),
    .wdata_i (wwdata),
    .raddr_i (w_q),
    .rdata_o (wrdata)
  );

  always_comb begin
    st_d        = st_q;
    tok_d       = tok_q;
    p_d         = p_q;
    j_d         = j_q;
    prev_d      = prev_q;
    last_d      = last_q;
    first_d     = first_q;
    err_d       = err_q;
    pbuf_d      = pbuf_q;
    k_d         = k_q;
    wa_d        = wa_q;
    w_d         = w_q;
    q_pop_o     = 1'b0;
    rel_o.valid = 1'b0;
    rel_o.bank  = tok_q.bank;
    wwe         = 1'b0;
    ov_d        = ov_q && !hint_o.ready;
    hw_d        = hw_q;
    wi_d        = wi_q;
    mf_d        = mf_q;
    lw_d        = lw_q;

    unique case (st_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          tok_d   = q_tok_i;
          err_d   = q_tok_i.count_err;
          p_d     = '0;
          prev_d  = '0;
          wa_d    = '0;
          w_d     = '0;
          st_d    = S_PSTART;
        end
      end
      S_PSTART: begin
        j_d     = prev_q;
        first_d = 1'b1;
        k_d     = '0;
        // a count that went backwards takes no indices
        st_d    = (prev_q < cnt_p) ? S_RD : S_FLUSH;
      end
      S_RD: begin
        st_d = S_EX;
      end
      S_EX: begin
        if (!first_q && (s_rdata_i <= last_q)) begin
          err_d = 1'b1;
        end
        // an index past the coefficient range sets nothing
        if ({1'b0, s_rdata_i} < 9'(COEFFS)) begin
          pbuf_d[s_rdata_i[PBI-1:0]] = 1'b1;
        end
        last_d  = s_rdata_i;
        first_d = 1'b0;
        j_d     = j_inc;
        st_d    = (j_inc < cnt_p) ? S_RD : S_FLUSH;
      end
      S_FLUSH: begin
        wwe  = 1'b1;
        wa_d = wa_q + 1'b1;
        k_d  = k_q + 1'b1;
        if (k_q == KW'(WPP - 1)) begin
          pbuf_d = '0;
          prev_d = cnt_p;
          p_d    = p_q + 1'b1;
          st_d   = (p_q == POLY_W'(POLYS - 1)) ? S_TSTART : S_PSTART;
        end
      end
      S_TSTART: begin
        j_d = prev_q;
        if (prev_q < 8'(MAX_HINTS)) begin
          st_d = S_TRD;
        end else begin
          rel_o.valid = 1'b1;
          st_d        = S_ERD;
        end
      end
      S_TRD: begin
        st_d = S_TEX;
      end
      S_TEX: begin
        // unused slots must be zero
        if (s_rdata_i != '0) begin
          err_d = 1'b1;
        end
        j_d = j_inc;
        if (j_inc < 8'(MAX_HINTS)) begin
          st_d = S_TRD;
        end else begin
          rel_o.valid = 1'b1;
          st_d        = S_ERD;
        end
      end
      S_ERD: begin
        if (!ov_q || hint_o.ready) begin
          st_d = S_ELD;
        end
      end
      S_ELD: begin
        ov_d = 1'b1;
        hw_d = wrdata;
        wi_d = WIDX_W'(w_q);
        mf_d = err_q;
        lw_d = w_last;
        w_d  = w_q + 1'b1;
        st_d = w_last ? S_IDLE : S_ERD;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ov_q   <= 1'b0;
      pbuf_q <= '0;
    end else begin
      st_q   <= st_d;
      ov_q   <= ov_d;
      pbuf_q <= pbuf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q   <= tok_d;
    p_q     <= p_d;
    j_q     <= j_d;
    prev_q  <= prev_d;
    last_q  <= last_d;
    first_q <= first_d;
    err_q   <= err_d;
    k_q     <= k_d;
    wa_q    <= wa_d;
    w_q     <= w_d;
    hw_q    <= hw_d;
    wi_q    <= wi_d;
    mf_q    <= mf_d;
    lw_q    <= lw_d;
  end

  assign hint_o.valid      = ov_q;
  assign hint_o.hint_word  = hw_q;
  assign hint_o.word_index = wi_q;
  assign hint_o.malformed  = mf_q;
  assign hint_o.last_word  = lw_q;

  a_ex_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_EX || st_q == S_TEX) |-> ($past(st_q) == S_RD || $past(st_q) == S_TRD))
    else $error("section byte used without a read the cycle before");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_ELD |-> !ov_q)
    else $error("output register loaded while still holding a word");

endmodule
